// ----- hw/rtl/ycc2rgb_pkg.sv -----
package ycc2rgb_pkg;

  localparam int CoefFracBitsDef = 16;
  localparam int GainFracBits    = 16;

  localparam int PixW    = 8;
  localparam int ModeW   = 2;
  localparam int GainW   = 18;
  localparam int OffsW   = 18;
  localparam int PaddrW  = 5;
  localparam int PdataW  = 32;
  localparam int TermW   = 21;
  localparam int NumChan = 3;

  typedef logic [PaddrW-3:0] reg_idx_t;

  localparam reg_idx_t RegMode        = reg_idx_t'(0);
  localparam reg_idx_t RegLumaGain    = reg_idx_t'(1);
  localparam reg_idx_t RegRedOffset   = reg_idx_t'(2);
  localparam reg_idx_t RegGreenOffset = reg_idx_t'(3);
  localparam reg_idx_t RegBlueOffset  = reg_idx_t'(4);

  typedef enum logic [ModeW-1:0] {
    ModePlain     = 2'd0,
    ModeLumaGain  = 2'd1,
    ModePostGain  = 2'd2,
    ModeIntMatrix = 2'd3
  } mode_e;

  localparam logic [GainW-1:0] GainUnity = GainW'(1 << GainFracBits);

  // integer matrix coefficients
  localparam logic signed [TermW-1:0] KIntY  = 21'sd298;
  localparam logic signed [TermW-1:0] KIntRv = 21'sd409;
  localparam logic signed [TermW-1:0] KIntGu = 21'sd100;
  localparam logic signed [TermW-1:0] KIntGv = 21'sd208;
  localparam logic signed [TermW-1:0] KIntBu = 21'sd516;

  localparam int RndIntMatrix = (128 << GainFracBits) + (1 << (GainFracBits - 1));
  localparam int IntShift     = GainFracBits + 8;

  typedef struct packed {
    mode_e                   mode;
    logic [GainW-1:0]        luma_gain;
    logic signed [OffsW-1:0] red_offset;
    logic signed [OffsW-1:0] green_offset;
    logic signed [OffsW-1:0] blue_offset;
  } cfg_t;

endpackage

// ----- hw/rtl/ycc2rgb_if.sv -----
interface ycc2rgb_ycc_if;
  import ycc2rgb_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] luma;
  logic [PixW-1:0] chroma_blue;
  logic [PixW-1:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink (input valid, input luma, input chroma_blue, input chroma_red,
                output ready);
endinterface

interface ycc2rgb_rgb_if;
  import ycc2rgb_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] red;
  logic [PixW-1:0] green;
  logic [PixW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/ycc2rgb_regs.sv -----
module ycc2rgb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ycc2rgb_pkg::PaddrW-1:0]   paddr,
  input  logic [ycc2rgb_pkg::PdataW-1:0]   pwdata,
  output logic [ycc2rgb_pkg::PdataW-1:0]   prdata,
  output logic                             pready,
  output ycc2rgb_pkg::cfg_t                cfg_o
);
  import ycc2rgb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[PaddrW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegMode:        cfg_d.mode         = mode_e'(pwdata[ModeW-1:0]);
        RegLumaGain:    cfg_d.luma_gain    = pwdata[GainW-1:0];
        RegRedOffset:   cfg_d.red_offset   = pwdata[OffsW-1:0];
        RegGreenOffset: cfg_d.green_offset = pwdata[OffsW-1:0];
        RegBlueOffset:  cfg_d.blue_offset  = pwdata[OffsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= ModePlain;
      cfg_q.luma_gain    <= GainUnity;
      cfg_q.red_offset   <= '0;
      cfg_q.green_offset <= '0;
      cfg_q.blue_offset  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      RegMode:        prdata = {{(PdataW-ModeW){1'b0}}, cfg_q.mode};
      RegLumaGain:    prdata = {{(PdataW-GainW){1'b0}}, cfg_q.luma_gain};
      RegRedOffset:   prdata = {{(PdataW-OffsW){1'b0}}, cfg_q.red_offset};
      RegGreenOffset: prdata = {{(PdataW-OffsW){1'b0}}, cfg_q.green_offset};
      RegBlueOffset:  prdata = {{(PdataW-OffsW){1'b0}}, cfg_q.blue_offset};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && idx == RegLumaGain |=> cfg_q.luma_gain == $past(pwdata[GainW-1:0]))
    else $error("luma gain write not taken");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && idx == RegMode |=> cfg_q.mode == mode_e'($past(pwdata[ModeW-1:0])))
    else $error("mode write not taken");

endmodule

// ----- hw/rtl/ycc2rgb_front.sv -----
module ycc2rgb_front #(
  parameter int CoefFracBits = ycc2rgb_pkg::CoefFracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ycc2rgb_pkg::cfg_t           cfg_i,
  ycc2rgb_ycc_if.sink                 ycc_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [CoefFracBits+30:0] acc_o [3]
);
  import ycc2rgb_pkg::*;

  localparam int F    = CoefFracBits;
  localparam int KW   = F + 2;
  localparam int MW   = KW + 9;
  localparam int AccW = F + 31;
  localparam int YgW  = PixW + GainW;

  localparam longint KRv = (longint'(1402)  * (longint'(1) << F) + 500)   / 1000;
  localparam longint KGu = (longint'(34414) * (longint'(1) << F) + 50000) / 100000;
  localparam longint KGv = (longint'(71414) * (longint'(1) << F) + 50000) / 100000;
  localparam longint KBu = (longint'(1772)  * (longint'(1) << F) + 500)   / 1000;

  localparam logic signed [MW-1:0] KRvC = MW'(KRv);
  localparam logic signed [MW-1:0] KGuC = MW'(KGu);
  localparam logic signed [MW-1:0] KGvC = MW'(KGv);
  localparam logic signed [MW-1:0] KBuC = MW'(KBu);

  logic                    rdy1, rdy2;
  logic                    v1_q, v2_q;
  logic signed [8:0]       u, v;
  logic signed [MW-1:0]    u_ext, v_ext;
  logic [GainW-1:0]        gain_eff;
  logic signed [TermW-1:0] y_t, cb_t, cr_t;
  logic signed [MW-1:0]    m_d  [NumChan];
  logic signed [MW-1:0]    m1_q [NumChan];
  logic signed [TermW-1:0] t_d  [NumChan];
  logic signed [TermW-1:0] t1_q [NumChan];
  logic [YgW-1:0]          yg_d, yg1_q;
  logic [PixW-1:0]         y1_q;
  logic signed [AccW-1:0]  yg_ext, ys_ext;
  logic signed [AccW-1:0]  acc_d  [NumChan];
  logic signed [AccW-1:0]  acc2_q [NumChan];

  assign rdy2        = !v2_q || ready_i;
  assign rdy1        = !v1_q || rdy2;
  assign ycc_i.ready = rdy1;

  // stage 1: matrix products and luma gain
  assign u        = $signed({1'b0, ycc_i.chroma_blue}) - 9'sd128;
  assign v        = $signed({1'b0, ycc_i.chroma_red}) - 9'sd128;
  assign u_ext    = MW'(u);
  assign v_ext    = MW'(v);
  assign gain_eff = (cfg_i.mode == ModeLumaGain) ? cfg_i.luma_gain : GainUnity;
  assign yg_d     = YgW'(ycc_i.luma) * YgW'(gain_eff);
  assign y_t      = TermW'({1'b0, ycc_i.luma});
  assign cb_t     = TermW'({1'b0, ycc_i.chroma_blue});
  assign cr_t     = TermW'({1'b0, ycc_i.chroma_red});

  always_comb begin
    m_d[0] = KRvC * v_ext;
    m_d[1] = -(KGuC * u_ext) - (KGvC * v_ext);
    m_d[2] = KBuC * u_ext;
    t_d[0] = KIntY * y_t + KIntRv * cr_t + TermW'($signed(cfg_i.red_offset));
    t_d[1] = KIntY * y_t - KIntGu * cb_t - KIntGv * cr_t
           + TermW'($signed(cfg_i.green_offset));
    t_d[2] = KIntY * y_t + KIntBu * cb_t + TermW'($signed(cfg_i.blue_offset));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= ycc_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ycc_i.valid && rdy1) begin
      y1_q  <= ycc_i.luma;
      yg1_q <= yg_d;
      m1_q  <= m_d;
      t1_q  <= t_d;
    end
  end

  // stage 2: per-channel operand for the gain stage
  assign yg_ext = AccW'(yg1_q);
  assign ys_ext = AccW'(y1_q);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      case (cfg_i.mode)
        ModePlain, ModeLumaGain:
          acc_d[c] = (yg_ext <<< F) + (AccW'(m1_q[c]) <<< GainFracBits);
        ModePostGain:
          acc_d[c] = (ys_ext <<< F) + AccW'(m1_q[c]);
        ModeIntMatrix:
          acc_d[c] = AccW'(t1_q[c]);
        default:
          acc_d[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      acc2_q <= acc_d;
    end
  end

  assign valid_o = v2_q;
  assign acc_o   = acc2_q;

  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !ready_i |=> v2_q && $stable(acc2_q[0]) && $stable(acc2_q[2]))
    else $error("stage 2 item lost while stalled");

endmodule

// ----- hw/rtl/ycc2rgb_back.sv -----
module ycc2rgb_back #(
  parameter int CoefFracBits = ycc2rgb_pkg::CoefFracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ycc2rgb_pkg::cfg_t           cfg_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [CoefFracBits+30:0] acc_i [3],
  ycc2rgb_rgb_if.source               rgb_o
);
  import ycc2rgb_pkg::*;

  localparam int F     = CoefFracBits;
  localparam int AccW  = F + 31;
  localparam int OpW   = F + 11;
  localparam int ProdW = OpW + GainW + 1;
  localparam int ShMat = F + GainFracBits;

  localparam logic signed [AccW-1:0] RndMat = AccW'(longint'(1) << (ShMat - 1));
  localparam logic signed [AccW-1:0] RndInt = AccW'(RndIntMatrix);

  logic                   rdy3, rdy4;
  logic                   v3_q, v4_q;
  logic                   use_gain, int_mode;
  logic signed [GainW:0]  gain_s;
  logic signed [ProdW-1:0] prod   [NumChan];
  logic signed [AccW-1:0] acc3_d [NumChan];
  logic signed [AccW-1:0] acc3_q [NumChan];
  logic signed [AccW-1:0] sum    [NumChan];
  logic signed [AccW-1:0] shr    [NumChan];
  logic [PixW-1:0]        pix_d  [NumChan];
  logic [PixW-1:0]        pix_q  [NumChan];

  assign rdy4    = !v4_q || rgb_o.ready;
  assign rdy3    = !v3_q || rdy4;
  assign ready_o = rdy3;

  assign int_mode = (cfg_i.mode == ModeIntMatrix);
  assign use_gain = (cfg_i.mode == ModePostGain) || int_mode;
  assign gain_s   = $signed({1'b0, cfg_i.luma_gain});

  // stage 3: gain multiply in post-gain and integer-matrix modes, else pass-through
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c]   = $signed(acc_i[c][OpW-1:0]) * gain_s;
      acc3_d[c] = use_gain ? AccW'(prod[c]) : acc_i[c];
    end
  end

  // stage 4: round, shift, saturate
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum[c] = acc3_q[c] + (int_mode ? RndInt : RndMat);
      shr[c] = int_mode ? (sum[c] >>> IntShift) : (sum[c] >>> ShMat);
      if (sum[c][AccW-1]) begin
        pix_d[c] = '0;
      end else if (|shr[c][AccW-1:PixW]) begin
        pix_d[c] = '1;
      end else begin
        pix_d[c] = shr[c][PixW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_q <= valid_i;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy3) begin
      acc3_q <= acc3_d;
    end
    if (v3_q && rdy4) begin
      pix_q <= pix_d;
    end
  end

  assign rgb_o.valid = v4_q;
  assign rgb_o.red   = pix_q[0];
  assign rgb_o.green = pix_q[1];
  assign rgb_o.blue  = pix_q[2];

  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy4 |=> v3_q && $stable(acc3_q[1]))
    else $error("stage 3 item lost while stalled");

  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> rdy3)
    else $error("back end stalls with an empty output stage");

endmodule

// ----- hw/rtl/ycbcr_to_rgb_gain_clip.sv -----
// ycbcr to rgb converter with luma gain and saturation
// input channel ycc_i carries one pixel (luma, chroma_blue, chroma_red) per item;
// output channel rgb_o carries the matching red, green, blue item, clipped to 0..255.
// both channels use valid/ready; an item moves on a clock edge with both high.
// the apb port sets mode, luma_gain and the three offsets; write them only while
// no item is in flight. pready is tied high, reads return the stored values.
// four register stages: matrix products and luma gain, per-channel operand,
// gain multiply, then round/shift/saturate into the output register.
// an accepted item passes the products, operand, gain and output registers in that
// order, and rgb_o.valid rises once it sits in the output register.
// throughput: one item per clock while rgb_o.ready stays high, set by the four-stage
// pipe with one gain multiplier per channel in the third stage.
// each stage holds its item while the next is full, so a stall on rgb_o fills
// the empty stages first and then drops ycc_i.ready; nothing is lost or repeated.
// reset clears all valid bits and loads mode 0, unity gain and zero offsets.
module ycbcr_to_rgb_gain_clip #(
  parameter int CoefFracBits = ycc2rgb_pkg::CoefFracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ycc2rgb_ycc_if.sink                    ycc_i,
  ycc2rgb_rgb_if.source                  rgb_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ycc2rgb_pkg::PaddrW-1:0] paddr,
  input  logic [ycc2rgb_pkg::PdataW-1:0] pwdata,
  output logic [ycc2rgb_pkg::PdataW-1:0] prdata,
  output logic                           pready
);
  import ycc2rgb_pkg::*;

  localparam int AccW = CoefFracBits + 31;

  cfg_t                   cfg;
  logic                   mid_valid;
  logic                   mid_ready;
  logic signed [AccW-1:0] mid_acc [NumChan];

  ycc2rgb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ycc2rgb_front #(
    .CoefFracBits (CoefFracBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .ycc_i   (ycc_i),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .acc_o   (mid_acc)
  );

  ycc2rgb_back #(
    .CoefFracBits (CoefFracBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .acc_i   (mid_acc),
    .rgb_o   (rgb_o)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ycc2rgb_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] chroma_red;
  } pix_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } rgb_t;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 8;

  localparam int FracSum = CoefFracBitsDef + GainFracBits;
  localparam longint KRv = ((longint'(1402) << CoefFracBitsDef) + 500) / 1000;
  localparam longint KGu = ((longint'(34414) << CoefFracBitsDef) + 50000) / 100000;
  localparam longint KGv = ((longint'(71414) << CoefFracBitsDef) + 50000) / 100000;
  localparam longint KBu = ((longint'(1772) << CoefFracBitsDef) + 500) / 1000;
  localparam longint HalfLsb = longint'(1) << (FracSum - 1);
  localparam longint GainOne = longint'(1) << GainFracBits;

  localparam logic [GainW-1:0] GainZero = '0;
  localparam logic [GainW-1:0] GainMax = '1;
  localparam logic signed [OffsW-1:0] OffsMax = {1'b0, {(OffsW-1){1'b1}}};
  localparam logic signed [OffsW-1:0] OffsMin = {1'b1, {(OffsW-1){1'b0}}};
  localparam cfg_t CfgReset = '{mode: ModePlain, luma_gain: GainUnity,
                                red_offset: '0, green_offset: '0, blue_offset: '0};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic pready;

  ycc2rgb_ycc_if ycc_bus ();
  ycc2rgb_rgb_if rgb_bus ();

  cfg_t model_cfg;
  rgb_t expected_rgb[$];
  rgb_t want_rgb;
  int mismatch_count = 0;
  int cycle_count = 0;
  int src_gap_pct;
  int rgb_stall_pct;

  ycbcr_to_rgb_gain_clip u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ycc_i   (ycc_bus),
    .rgb_o   (rgb_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [PixW-1:0] clip_shift(input longint acc, input int sh);
    longint v;
    if (acc < 0) return '0;
    v = acc >>> sh;
    return (v > 255) ? '1 : v[PixW-1:0];
  endfunction

  function automatic rgb_t convert_pixel(input pix_t p);
    longint y, cb, cr, g, u, v, mr, mg, mb, yt, ys, yl, gain;
    rgb_t r;
    y = longint'(p.luma);
    cb = longint'(p.chroma_blue);
    cr = longint'(p.chroma_red);
    g = longint'(model_cfg.luma_gain);
    u = cb - 128;
    v = cr - 128;
    mr = KRv * v;
    mg = -(KGu * u) - (KGv * v);
    mb = KBu * u;
    case (model_cfg.mode)
      ModeIntMatrix: begin
        yt = longint'(KIntY) * y;
        r.red = clip_shift((yt + longint'(KIntRv) * cr + longint'(model_cfg.red_offset)) * g
                           + longint'(RndIntMatrix), IntShift);
        r.green = clip_shift((yt - longint'(KIntGu) * cb - longint'(KIntGv) * cr
                             + longint'(model_cfg.green_offset)) * g
                             + longint'(RndIntMatrix), IntShift);
        r.blue = clip_shift((yt + longint'(KIntBu) * cb + longint'(model_cfg.blue_offset)) * g
                            + longint'(RndIntMatrix), IntShift);
      end
      ModePostGain: begin
        ys = y << CoefFracBitsDef;
        r.red = clip_shift((ys + mr) * g + HalfLsb, FracSum);
        r.green = clip_shift((ys + mg) * g + HalfLsb, FracSum);
        r.blue = clip_shift((ys + mb) * g + HalfLsb, FracSum);
      end
      default: begin
        gain = (model_cfg.mode == ModeLumaGain) ? g : GainOne;
        yl = (y * gain) << CoefFracBitsDef;
        r.red = clip_shift(yl + mr * GainOne + HalfLsb, FracSum);
        r.green = clip_shift(yl + mg * GainOne + HalfLsb, FracSum);
        r.blue = clip_shift(yl + mb * GainOne + HalfLsb, FracSum);
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [PixW-1:0] want,
                             input logic [PixW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rgb_bus.valid && rgb_bus.ready) begin
      if (expected_rgb.size() == 0) begin
        $display("%0t: rgb item with nothing expected, expected none, actual %0d %0d %0d",
                 $time, rgb_bus.red, rgb_bus.green, rgb_bus.blue);
        mismatch_count++;
      end else begin
        want_rgb = expected_rgb.pop_front();
        check_field("red", want_rgb.red, rgb_bus.red);
        check_field("green", want_rgb.green, rgb_bus.green);
        check_field("blue", want_rgb.blue, rgb_bus.blue);
      end
    end
    rgb_bus.ready <= ($urandom_range(0, 99) >= rgb_stall_pct);
  end

  task automatic send_pixel(input pix_t p);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      ycc_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    ycc_bus.valid <= 1'b1;
    ycc_bus.luma <= p.luma;
    ycc_bus.chroma_blue <= p.chroma_blue;
    ycc_bus.chroma_red <= p.chroma_red;
    @(posedge clk_i);
    while (!ycc_bus.ready) @(posedge clk_i);
    expected_rgb.push_back(convert_pixel(p));
  endtask

  task automatic drain_pixels();
    ycc_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_rgb.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegMode:        model_cfg.mode = mode_e'(data[ModeW-1:0]);
      RegLumaGain:    model_cfg.luma_gain = data[GainW-1:0];
      RegRedOffset:   model_cfg.red_offset = data[OffsW-1:0];
      RegGreenOffset: model_cfg.green_offset = data[OffsW-1:0];
      RegBlueOffset:  model_cfg.blue_offset = data[OffsW-1:0];
      default: ;
    endcase
  endtask

  // junk in the bits above the field
  function automatic logic [PdataW-1:0] pad_word(input logic [PdataW-1:0] field, input int w);
    logic [PdataW-1:0] mask;
    mask = (32'd1 << w) - 1;
    return ($urandom() & ~mask) | (field & mask);
  endfunction

  task automatic set_cfg(input cfg_t c);
    drain_pixels();
    write_reg(RegMode, pad_word(PdataW'(c.mode), ModeW));
    write_reg(RegLumaGain, pad_word(PdataW'(c.luma_gain), GainW));
    write_reg(RegRedOffset, pad_word(PdataW'(c.red_offset), OffsW));
    write_reg(RegGreenOffset, pad_word(PdataW'(c.green_offset), OffsW));
    write_reg(RegBlueOffset, pad_word(PdataW'(c.blue_offset), OffsW));
  endtask

  function automatic logic [PixW-1:0] rand_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return PixW'($urandom());
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p.luma = rand_sample();
    p.chroma_blue = rand_sample();
    p.chroma_red = rand_sample();
    return p;
  endfunction

  function automatic logic signed [OffsW-1:0] rand_offset();
    case ($urandom_range(0, 4))
      0: return OffsMax;
      1: return OffsMin;
      2: return OffsW'($urandom());
      default: return OffsW'(int'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  task automatic test_reset_values();
    send_pixel('{luma: 8'd0, chroma_blue: 8'd0, chroma_red: 8'd0});
    send_pixel('{luma: 8'd255, chroma_blue: 8'd255, chroma_red: 8'd255});
    send_pixel('{luma: 8'd255, chroma_blue: 8'd0, chroma_red: 8'd255});
  endtask

  task automatic test_mode_corners();
    cfg_t c;
    for (int m = ModePlain; m <= ModeIntMatrix; m++) begin
      c = CfgReset;
      c.mode = mode_e'(m);
      c.luma_gain = GainW'(int'(GainUnity) * 3 / 4);
      c.red_offset = 18'sd256;
      c.green_offset = -18'sd256;
      set_cfg(c);
      send_pixel('{luma: 8'd0, chroma_blue: 8'd255, chroma_red: 8'd255});
      send_pixel('{luma: 8'd255, chroma_blue: 8'd0, chroma_red: 8'd0});
      send_pixel('{luma: 8'd128, chroma_blue: 8'd128, chroma_red: 8'd128});
    end
  endtask

  task automatic test_gain_extremes();
    cfg_t c;
    c = CfgReset;
    c.luma_gain = GainZero;
    for (int m = ModeLumaGain; m <= ModeIntMatrix; m++) begin
      c.mode = mode_e'(m);
      set_cfg(c);
      send_pixel('{luma: 8'd255, chroma_blue: 8'd255, chroma_red: 8'd255});
    end
    c.luma_gain = GainMax;
    for (int m = ModePostGain; m <= ModeIntMatrix; m++) begin
      c.mode = mode_e'(m);
      set_cfg(c);
      send_pixel('{luma: 8'd64, chroma_blue: 8'd100, chroma_red: 8'd160});
    end
  endtask

  task automatic test_offset_extremes();
    cfg_t c;
    c = CfgReset;
    c.mode = ModeIntMatrix;
    c.red_offset = OffsMax;
    c.green_offset = OffsMax;
    c.blue_offset = OffsMax;
    set_cfg(c);
    send_pixel('{luma: 8'd0, chroma_blue: 8'd0, chroma_red: 8'd0});
    c.red_offset = OffsMin;
    c.green_offset = OffsMin;
    c.blue_offset = OffsMin;
    set_cfg(c);
    send_pixel('{luma: 8'd255, chroma_blue: 8'd255, chroma_red: 8'd255});
  endtask

  task automatic test_unmapped_regs();
    cfg_t c;
    c = CfgReset;
    c.mode = ModeIntMatrix;
    c.luma_gain = GainW'(70000);
    c.red_offset = -18'sd3000;
    c.green_offset = 18'sd5000;
    c.blue_offset = -18'sd20000;
    set_cfg(c);
    for (int i = RegBlueOffset + 1; i < (1 << (PaddrW - 2)); i++)
      write_reg(reg_idx_t'(i), $urandom());
    send_pixel('{luma: 8'd100, chroma_blue: 8'd50, chroma_red: 8'd200});
  endtask

  task automatic test_random_settings(input int n_settings, input int n_items);
    cfg_t c;
    for (int s = 0; s < n_settings; s++) begin
      c.mode = mode_e'(s % 4);
      case ($urandom_range(0, 4))
        0: c.luma_gain = GainZero;
        1: c.luma_gain = GainMax;
        2: c.luma_gain = GainUnity;
        3: c.luma_gain = GainW'($urandom());
        default: c.luma_gain = GainW'($urandom_range(32768, 98304));
      endcase
      c.red_offset = rand_offset();
      c.green_offset = rand_offset();
      c.blue_offset = rand_offset();
      set_cfg(c);
      for (int i = 0; i < n_items; i++) begin
        // hold off until the pipe is empty
        if (i == n_items / 2) drain_pixels();
        send_pixel(rand_pixel());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ycc_bus.valid = 1'b0;
    ycc_bus.luma = '0;
    ycc_bus.chroma_blue = '0;
    ycc_bus.chroma_red = '0;
    rgb_bus.ready = 1'b0;
    model_cfg = CfgReset;
    src_gap_pct = 28;
    rgb_stall_pct = 78;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_mode_corners();
    test_gain_extremes();
    test_offset_extremes();
    test_unmapped_regs();

    test_random_settings(9, 50);
    src_gap_pct = 78;
    rgb_stall_pct = 28;
    test_random_settings(9, 50);
    src_gap_pct = 0;
    rgb_stall_pct = 0;
    test_random_settings(9, 50);

    drain_pixels();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
